@@ rtl/core/bdq_pkg.sv @@
// shared types and codes for the bounded deque with sorted insert
package bdq_pkg;

    localparam int DEFAULT_CAPACITY = 16;
    localparam int WORD_W           = 32;
    localparam int CMD_W            = 3;
    localparam int STATUS_W         = 2;
    localparam int COUNT_W          = 5;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic [COUNT_W-1:0]       count_field_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT    = 3'd0,
        CMD_PUSH_BACK     = 3'd1,
        CMD_POP_FRONT     = 3'd2,
        CMD_POP_BACK      = 3'd3,
        CMD_REMOVE        = 3'd4,
        CMD_SORTED_INSERT = 3'd5
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    // what every cell does in this cycle
    typedef enum logic [2:0] {
        CM_HOLD,
        CM_PUSH_FRONT,
        CM_PUSH_BACK,
        CM_SORTED,
        CM_POP_FRONT,
        CM_POP_BACK,
        CM_REMOVE
    } cell_mode_t;

    typedef struct packed {
        cell_mode_t mode;
        word_t      operand;
    } cell_ctrl_t;

endpackage

@@ rtl/core/bdq_ifs.sv @@
// valid/ready channel interfaces for command and result beats
interface bdq_in_if;
    logic                    valid;
    logic                    ready;
    logic [2:0]              command;
    bdq_pkg::word_t          operand_value;

    modport source (output valid, output command, output operand_value, input ready);
    modport sink   (input valid, input command, input operand_value, output ready);
endinterface

interface bdq_out_if;
    logic                    valid;
    logic                    ready;
    bdq_pkg::word_t          extracted_value;
    logic [1:0]              status;
    bdq_pkg::count_field_t   entry_count;

    modport source (output valid, output extracted_value, output status,
                    output entry_count, input ready);
    modport sink   (input valid, input extracted_value, input status,
                    input entry_count, output ready);
endinterface

@@ rtl/core/bounded_deque_with_sorted_insert_core.sv @@
// top level: bounded deque with sorted insert built as a row of shift cells
//
// usage
//   in_ch carries command beats (command, operand_value), out_ch carries one
//   result beat per command (extracted_value, status, entry_count).
//   commands: push front, push back, pop front, pop back, remove first equal
//   value, sorted insert (before the first greater entry, else at the back).
//   every position is a cell that compares against the operand and takes its
//   left or right neighbor's word in the same cycle; the result beat is valid
//   the cycle after the command beat. throughput is one command per cycle
//   while the receiver does not stall; the ripple chains of insert point,
//   match and extracted word through all CAPACITY cells set the cycle time.
//   a full store refuses inserts (status full), an empty one refuses pops and
//   removes (status empty); a remove with no match reports not found.
//   reset clears the count and every cell valid flag; stored words are not
//   cleared and are never read before being written.
//   the result sits in an output register; when the receiver stalls a new
//   command is taken only if the register frees up in the same cycle.
module bounded_deque_with_sorted_insert_core
#(
    parameter int CAPACITY = bdq_pkg::DEFAULT_CAPACITY
)
(
    input  logic   clk,
    input  logic   rst_n,
    bdq_in_if.sink   in_ch,
    bdq_out_if.source out_ch
);
    import bdq_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    // occupancy
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          full;
    logic          empty;

    // output register
    logic          out_valid_reg;
    word_t         out_value_reg;
    status_t       out_status_reg;
    count_field_t  out_count_reg;

    logic          accept;
    cell_ctrl_t    ctrl;
    status_t       status_dec;
    status_t       status_now;
    logic [CW+COUNT_W-1:0] count_wide;

    // cell row and neighbor chains
    word_t                 cell_value [CAPACITY];
    logic [CAPACITY-1:0]   cell_valid;
    logic [CAPACITY:0]     ins_chain;
    logic [CAPACITY:0]     rm_chain;
    word_t                 ext_chain [CAPACITY+1];

    assign full   = (count_reg == CW'(CAPACITY));
    assign empty  = (count_reg == '0);
    assign accept = in_ch.valid && in_ch.ready;

    // a new beat goes in when the result slot is free or being drained
    assign in_ch.ready = !out_valid_reg || out_ch.ready;

    // decode the command into a cell mode, refusing what cannot be done
    always_comb
    begin
        ctrl.mode    = CM_HOLD;
        ctrl.operand = in_ch.operand_value;
        status_dec   = ST_OK;
        unique case (in_ch.command)
            CMD_PUSH_FRONT:
            begin
                if (full) status_dec = ST_FULL;
                else      ctrl.mode  = CM_PUSH_FRONT;
            end
            CMD_PUSH_BACK:
            begin
                if (full) status_dec = ST_FULL;
                else      ctrl.mode  = CM_PUSH_BACK;
            end
            CMD_SORTED_INSERT:
            begin
                if (full) status_dec = ST_FULL;
                else      ctrl.mode  = CM_SORTED;
            end
            CMD_POP_FRONT:
            begin
                if (empty) status_dec = ST_EMPTY;
                else       ctrl.mode  = CM_POP_FRONT;
            end
            CMD_POP_BACK:
            begin
                if (empty) status_dec = ST_EMPTY;
                else       ctrl.mode  = CM_POP_BACK;
            end
            CMD_REMOVE:
            begin
                if (empty) status_dec = ST_EMPTY;
                else       ctrl.mode  = CM_REMOVE;
            end
            default:
            begin
                // unused codes leave the list alone
                status_dec = ST_OK;
            end
        endcase
        if (!accept) ctrl.mode = CM_HOLD;
    end

    // a remove that ran through the whole row without a match is not found
    assign status_now = (ctrl.mode == CM_REMOVE && !rm_chain[CAPACITY]) ? ST_NOT_FOUND
                                                                         : status_dec;

    // chain heads: nothing happened to the left of the front cell
    assign ins_chain[0] = 1'b0;
    assign rm_chain[0]  = 1'b0;
    assign ext_chain[0] = '0;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        word_t lv;
        logic  lvld;
        word_t rv;
        logic  rvld;

        if (i == 0)
        begin : g_front
            assign lv   = '0;
            assign lvld = 1'b1;
        end
        else
        begin : g_inner_l
            assign lv   = cell_value[i-1];
            assign lvld = cell_valid[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_back
            assign rv   = '0;
            assign rvld = 1'b0;
        end
        else
        begin : g_inner_r
            assign rv   = cell_value[i+1];
            assign rvld = cell_valid[i+1];
        end

        bdq_cell u_cell
        (
            .clk            (clk),
            .rst_n          (rst_n),
            .ctrl           (ctrl),
            .left_value     (lv),
            .left_valid     (lvld),
            .right_value    (rv),
            .right_valid    (rvld),
            .ins_before_in  (ins_chain[i]),
            .ins_before_out (ins_chain[i+1]),
            .rm_before_in   (rm_chain[i]),
            .rm_before_out  (rm_chain[i+1]),
            .ext_in         (ext_chain[i]),
            .ext_out        (ext_chain[i+1]),
            .value          (cell_value[i]),
            .valid          (cell_valid[i])
        );
    end

    // count follows what the cells actually did
    always_comb
    begin
        count_next = count_reg;
        unique case (ctrl.mode)
            CM_PUSH_FRONT, CM_PUSH_BACK, CM_SORTED:
                count_next = count_reg + CW'(1);
            CM_POP_FRONT, CM_POP_BACK:
                count_next = count_reg - CW'(1);
            CM_REMOVE:
                if (rm_chain[CAPACITY]) count_next = count_reg - CW'(1);
            default:
                count_next = count_reg;
        endcase
    end

    // report the count masked to the result field width
    assign count_wide = {{COUNT_W{1'b0}}, count_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_value_reg  <= ext_chain[CAPACITY];
            out_status_reg <= status_now;
            out_count_reg  <= count_wide[COUNT_W-1:0];
        end
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.extracted_value = out_value_reg;
    assign out_ch.status          = out_status_reg;
    assign out_ch.entry_count     = out_count_reg;

`ifndef SYNTH
    // occupancy never passes the capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("count above capacity");

    // cell valid flags always agree with the count
    a_valid_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(cell_valid) == int'(count_reg))
        else $error("cell valid flags disagree with count");

    // a refused insert leaves the count unchanged
    a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
        accept && status_now == ST_FULL |=> $stable(count_reg))
        else $error("count moved on a full insert");

    // every accepted beat shows up as a result in the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("accepted beat produced no result");
`endif

endmodule

@@ rtl/core/bdq_cell.sv @@
// one deque position: holds a word and its valid flag, shifts with its neighbors
module bdq_cell
(
    input  logic               clk,
    input  logic               rst_n,
    input  bdq_pkg::cell_ctrl_t ctrl,
    input  bdq_pkg::word_t     left_value,
    input  logic               left_valid,
    input  bdq_pkg::word_t     right_value,
    input  logic               right_valid,
    input  logic               ins_before_in,
    output logic               ins_before_out,
    input  logic               rm_before_in,
    output logic               rm_before_out,
    input  bdq_pkg::word_t     ext_in,
    output bdq_pkg::word_t     ext_out,
    output bdq_pkg::word_t     value,
    output logic               valid
);
    import bdq_pkg::*;

    word_t value_reg;
    word_t value_next;
    logic  valid_reg;
    logic  valid_next;
    logic  ins_here;
    logic  rm_here;
    logic  is_insert;

    // local insert point / removal point for this position
    always_comb
    begin
        ins_here  = 1'b0;
        rm_here   = 1'b0;
        is_insert = 1'b0;
        unique case (ctrl.mode)
            CM_PUSH_FRONT:
            begin
                is_insert = 1'b1;
                ins_here  = 1'b1;
            end
            CM_PUSH_BACK:
            begin
                is_insert = 1'b1;
                ins_here  = !valid_reg;
            end
            CM_SORTED:
            begin
                is_insert = 1'b1;
                ins_here  = !valid_reg || (ctrl.operand < value_reg);
            end
            CM_POP_FRONT: rm_here = 1'b1;
            CM_POP_BACK:  rm_here = valid_reg && !right_valid;
            CM_REMOVE:    rm_here = valid_reg && (value_reg == ctrl.operand);
            CM_HOLD:      rm_here = 1'b0;
            default:      rm_here = 1'b0;
        endcase
    end

    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (is_insert)
        begin
            if (ins_before_in)
            begin
                value_next = left_value;
                valid_next = left_valid;
            end
            else if (ins_here)
            begin
                value_next = ctrl.operand;
                valid_next = 1'b1;
            end
        end
        else if (rm_before_in || rm_here)
        begin
            value_next = right_value;
            valid_next = right_valid;
        end
    end

    assign ins_before_out = ins_before_in || (is_insert && ins_here);
    assign rm_before_out  = rm_before_in || rm_here;
    assign ext_out        = (rm_here && !rm_before_in) ? value_reg : ext_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign valid = valid_reg;

endmodule
